// ----- design/heat_diffusion_stencil_defines.svh -----
// Assertion macros shared by the checker of the heat diffusion stencil.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef HEAT_DIFFUSION_STENCIL_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hds_pkg.sv -----
// Shared constants and types of the heat diffusion stencil.
// No dependencies; the interfaces, the top level and the checker refer to it by scoped names.
`default_nettype none

package hds_pkg;

	// Default parameter values.
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_TEMP_BITS = 24;

	// Fixed field widths.
	localparam int GRID_WIDTH_BITS  = 11;
	localparam int GRID_HEIGHT_BITS = 13;
	localparam int RATE_BITS        = 15;
	localparam int ROW_BITS         = 12;
	localparam int OUT_COL_BITS     = 10;
	localparam int CFG_DATA_BITS    = 15;
	localparam int CFG_INDEX_BITS   = 2;

	// Largest grid height that the row counter supports.
	localparam int MAX_HEIGHT = 4096;

	// Register reset values.
	localparam int GRID_WIDTH_RST  = 64;
	localparam int GRID_HEIGHT_RST = 64;
	localparam int RATE_RST        = 6554;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_RATE        = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/hds_if.sv -----
// Valid/ready channel interfaces of the heat diffusion stencil.
// Depends on hds_pkg for default widths.
`default_nettype none

// Input channel: one grid temperature per item.
interface hds_in_if #(
	parameter int TEMP_BITS = hds_pkg::DEF_TEMP_BITS
) ();
	logic                        valid;
	logic                        ready;
	logic signed [TEMP_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// Output channel: one updated cell per item, tagged with its position.
interface hds_out_if #(
	parameter int TEMP_BITS = hds_pkg::DEF_TEMP_BITS
) ();
	logic                                   valid;
	logic                                   ready;
	logic signed [TEMP_BITS-1:0]            temp_out;
	logic [hds_pkg::ROW_BITS-1:0]           out_row;
	logic [hds_pkg::OUT_COL_BITS-1:0]       out_col;
	logic                                   run_last;
	logic                                   frame_last;

	modport source (output valid, output temp_out, output out_row, output out_col,
		output run_last, output frame_last, input ready);
	modport sink (input valid, input temp_out, input out_row, input out_col,
		input run_last, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- design/hds_line_store.sv -----
// Line store of the stencil: one synchronous memory, one read and one write port.
// The read data is registered and holds while no read is issued. No dependencies.
`default_nettype none

module hds_line_store #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 48
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- design/heat_diffusion_stencil.sv -----
// Top level of the five-point heat diffusion stencil over a raster-order grid stream.
// Depends on hds_pkg, hds_if (channel interfaces) and hds_line_store (row memory).
//
//   channel   | direction | payload
//   ----------+-----------+--------------------------------------------------
//   samples   | in        | sample_in
//   results   | out       | temp_out, out_row, out_col, run_last, frame_last
//   cfg port  | in        | cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// One item is accepted per cycle unless results stall or the output register holds two results.
// An item with two results (interior cell finished plus border cell) holds the output
// register until both results have left, stalling the item behind it.
// The pace is set by the single output register and the one-per-cycle line store port.
// arst_n clears counters and valid bits and resets config registers, not the line store.
// A stall on results backs up through the pipeline stages to samples.ready.
`default_nettype none

module heat_diffusion_stencil #(
	parameter int MAX_WIDTH = hds_pkg::DEF_MAX_WIDTH,
	parameter int TEMP_BITS = hds_pkg::DEF_TEMP_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [hds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [hds_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	hds_in_if.sink                             samples,
	hds_out_if.source                          results
);

	localparam int T   = TEMP_BITS;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int GW  = hds_pkg::GRID_WIDTH_BITS;
	localparam int HW  = hds_pkg::GRID_HEIGHT_BITS;
	localparam int RW  = hds_pkg::ROW_BITS;
	localparam int OCW = hds_pkg::OUT_COL_BITS;
	localparam int RTW = hds_pkg::RATE_BITS;
	localparam int XW  = ((CW > GW) ? CW : GW) + 1;
	// Laplacian, product and sum widths.
	localparam int LW  = T + 4;
	localparam int PW  = LW + RTW + 1;
	localparam int SW  = LW + 1;
	localparam logic signed [T-1:0] TMAX = {1'b0, {(T-1){1'b1}}};
	localparam logic signed [T-1:0] TMIN = {1'b1, {(T-1){1'b0}}};

	// Configuration registers.
	logic [GW-1:0]  grid_width_q;
	logic [HW-1:0]  grid_height_q;
	logic [RTW-1:0] rate_q;

	// Position counters.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Clamped last column and last row.
	logic [XW-1:0] gw_x;
	logic [XW-1:0] col_last_x;
	logic [CW-1:0] col_last;
	logic [HW-1:0] row_last_x;
	logic [RW-1:0] row_last;

	logic col_end, row_end, interior_c, border_c, flast_c;
	logic in_fire;

	// Stage 1: sample and line store read data.
	logic                v_s1;
	logic signed [T-1:0] samp_s1;
	logic [CW-1:0]       col_s1;
	logic [RW-1:0]       row_s1;
	logic                int_s1, bord_s1, flast_s1;
	logic [2*T-1:0]      rd_data;
	logic signed [T-1:0] mid_rd, top_rd;

	// Neighbor window.
	logic signed [T-1:0] top1_q, mid1_q, mid2_q, bot1_q;
	logic signed [LW-1:0] lap_c;

	// Stage 2: Laplacian.
	logic                 v_s2;
	logic signed [LW-1:0] lap_s2;
	logic signed [T-1:0]  ctr_s2, samp_s2;
	logic [CW-1:0]        col_s2;
	logic [RW-1:0]        row_s2;
	logic                 int_s2, bord_s2, flast_s2;

	// Stage 3: rate product.
	logic                 v_s3;
	logic signed [PW-1:0] prod_c, prod_s3;
	logic signed [T-1:0]  ctr_s3, samp_s3;
	logic [CW-1:0]        col_s3;
	logic [RW-1:0]        row_s3;
	logic                 int_s3, bord_s3, flast_s3;
	logic signed [SW-1:0] sum_c;
	logic signed [T-1:0]  temp_c;

	// Stage 4: output register with up to two pending results.
	logic                pend_int_q, pend_bord_q;
	logic signed [T-1:0] temp_s4, samp_s4;
	logic [CW-1:0]       col_s4, col_sel;
	logic [RW-1:0]       row_s4;
	logic                flast_s4;

	logic adv4, en3, en2, en1, fire1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GW'(hds_pkg::GRID_WIDTH_RST);
			grid_height_q <= HW'(hds_pkg::GRID_HEIGHT_RST);
			rate_q        <= RTW'(hds_pkg::RATE_RST);
		end else if (cfg_wr_en) begin
			case (hds_pkg::cfg_reg_t'(cfg_index))
				hds_pkg::CFG_GRID_WIDTH: begin
					grid_width_q <= cfg_wdata[GW-1:0];
				end
				hds_pkg::CFG_GRID_HEIGHT: begin
					grid_height_q <= cfg_wdata[HW-1:0];
				end
				hds_pkg::CFG_RATE: begin
					rate_q <= cfg_wdata[RTW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the grid size and derive the last column and row.
	assign gw_x = XW'(grid_width_q);

	always_comb begin
		if (gw_x < XW'(3)) begin
			col_last_x = XW'(2);
		end else if (gw_x > XW'(MAX_WIDTH)) begin
			col_last_x = XW'(MAX_WIDTH - 1);
		end else begin
			col_last_x = gw_x - XW'(1);
		end
		if (grid_height_q < HW'(3)) begin
			row_last_x = HW'(2);
		end else if (grid_height_q > HW'(hds_pkg::MAX_HEIGHT)) begin
			row_last_x = HW'(hds_pkg::MAX_HEIGHT - 1);
		end else begin
			row_last_x = grid_height_q - HW'(1);
		end
	end

	assign col_last = col_last_x[CW-1:0];
	assign row_last = row_last_x[RW-1:0];

	// Classify the incoming cell.
	assign col_end    = col_q >= col_last;
	assign row_end    = row_q >= row_last;
	assign interior_c = (row_q >= RW'(2)) && (col_q >= CW'(2))
		&& (row_q <= row_last) && (col_q <= col_last);
	assign border_c   = (row_q == '0) || (col_q == '0) || row_end || col_end;
	assign flast_c    = row_end && col_end;

	// Pipeline advance: each stage moves when the next one is empty or moving.
	assign adv4  = !(pend_int_q || pend_bord_q)
		|| (results.ready && !(pend_int_q && pend_bord_q));
	assign en3   = !v_s3 || adv4;
	assign en2   = !v_s2 || en3;
	assign en1   = !v_s1 || en2;
	assign fire1 = v_s1 && en2;

	assign samples.ready = en1;
	assign in_fire       = samples.valid && en1;

	// Raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Row memory: upper half holds two rows above, lower half one row above.
	hds_line_store #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (2 * T)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (fire1),
		.wr_addr (col_s1),
		.wr_data ({mid_rd, samp_s1})
	);

	assign mid_rd = rd_data[T-1:0];
	assign top_rd = rd_data[2*T-1:T];

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= samples.valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			samp_s1  <= samples.sample_in;
			col_s1   <= col_q;
			row_s1   <= row_q;
			int_s1   <= interior_c;
			bord_s1  <= border_c;
			flast_s1 <= flast_c;
		end
	end

	// Laplacian of the cell one row up and one column back.
	assign lap_c = LW'(top1_q) + LW'(bot1_q) + LW'(mid_rd) + LW'(mid2_q)
		- (LW'(mid1_q) <<< 2);

	// Neighbor window shifts once per item leaving stage 1.
	always_ff @(posedge clk) begin
		if (fire1) begin
			top1_q <= top_rd;
			mid2_q <= mid1_q;
			mid1_q <= mid_rd;
			bot1_q <= samp_s1;
		end
	end

	// Stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			lap_s2   <= lap_c;
			ctr_s2   <= mid1_q;
			samp_s2  <= samp_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			int_s2   <= int_s1;
			bord_s2  <= bord_s1;
			flast_s2 <= flast_s1;
		end
	end

	// Stage 3: rate times Laplacian.
	assign prod_c = $signed({1'b0, rate_q}) * lap_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			prod_s3  <= prod_c;
			ctr_s3   <= ctr_s2;
			samp_s3  <= samp_s2;
			col_s3   <= col_s2;
			row_s3   <= row_s2;
			int_s3   <= int_s2;
			bord_s3  <= bord_s2;
			flast_s3 <= flast_s2;
		end
	end

	// Add the floored delta to the center and saturate.
	assign sum_c = SW'(ctr_s3) + SW'($signed(prod_s3[PW-1:RTW+1]));

	always_comb begin
		if (sum_c > SW'(TMAX)) begin
			temp_c = TMAX;
		end else if (sum_c < SW'(TMIN)) begin
			temp_c = TMIN;
		end else begin
			temp_c = sum_c[T-1:0];
		end
	end

	// Stage 4 pending flags: interior result goes out first, border result last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_int_q  <= 1'b0;
			pend_bord_q <= 1'b0;
		end else if (adv4) begin
			pend_int_q  <= v_s3 && int_s3;
			pend_bord_q <= v_s3 && bord_s3;
		end else if (results.ready && pend_int_q) begin
			pend_int_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			temp_s4  <= temp_c;
			samp_s4  <= samp_s3;
			col_s4   <= col_s3;
			row_s4   <= row_s3;
			flast_s4 <= flast_s3;
		end
	end

	// Output selection.
	assign col_sel = pend_int_q ? col_s4 - CW'(1) : col_s4;

	assign results.valid      = pend_int_q || pend_bord_q;
	assign results.temp_out   = pend_int_q ? temp_s4 : samp_s4;
	assign results.out_row    = pend_int_q ? row_s4 - RW'(1) : row_s4;
	assign results.out_col    = OCW'(col_sel);
	assign results.run_last   = !(pend_int_q && pend_bord_q);
	assign results.frame_last = !pend_int_q && flast_s4;

endmodule

`default_nettype wire

// ----- design/hds_checker.sv -----
// Port-level checker of the heat diffusion stencil, bound to the top level.
// Depends on hds_pkg and the macros in heat_diffusion_stencil_defines.svh.
`default_nettype none
`include "heat_diffusion_stencil_defines.svh"

module hds_checker #(
	parameter int TEMP_BITS = hds_pkg::DEF_TEMP_BITS
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [TEMP_BITS-1:0]         temp_out,
	input wire logic [hds_pkg::ROW_BITS-1:0]        out_row,
	input wire logic [hds_pkg::OUT_COL_BITS-1:0]    out_col,
	input wire logic                                run_last,
	input wire logic                                frame_last
);

	// A stalled result holds its payload.
	`HDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(temp_out) && $stable(out_row) && $stable(out_col) && $stable(run_last), "stalled result changed")

	// The final cell of a frame always ends its item's results.
	`HDS_ASSERT_NOW(a_flast_run, out_valid && frame_last, run_last, "frame_last without run_last")

	// An interior result that is not last is followed at once by the border result.
	`HDS_ASSERT_NEXT(a_pair_next, out_valid && out_ready && !run_last, out_valid && run_last, "second result missing")

	// The border result of a pair sits one row and one column past the interior one.
	`HDS_ASSERT_NEXT(a_pair_pos, out_valid && out_ready && !run_last, (out_row == $past(out_row) + 12'd1) && (out_col == $past(out_col) + 10'd1), "pair position mismatch")

endmodule

bind heat_diffusion_stencil hds_checker #(
	.TEMP_BITS (TEMP_BITS)
) u_hds_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.temp_out   (results.temp_out),
	.out_row    (results.out_row),
	.out_col    (results.out_col),
	.run_last   (results.run_last),
	.frame_last (results.frame_last)
);

`default_nettype wire
